// ===== hdl/aes_block_cipher_macros.svh =====
// Assertion macros used by the cipher's top-level RTL.
`ifndef AES_BLOCK_CIPHER_MACROS_SVH
`define AES_BLOCK_CIPHER_MACROS_SVH
// Assert that an implication holds at every clock edge outside reset.
`define AES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Assert that an implication holds in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

  // Round-key store: one 128-bit entry per round key, 15 at most.
  localparam int unsigned RkRounds = 15;
  localparam int unsigned RkAddrW  = 6;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_W0   = 3'd1;
  localparam logic [2:0] REG_KEY_W1   = 3'd2;
  localparam logic [2:0] REG_KEY_W2   = 3'd3;
  localparam logic [2:0] REG_KEY_W3   = 3'd4;

  // Request types.
  localparam logic REQ_ENC = 1'b0;
  localparam logic REQ_DEC = 1'b1;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_KLOAD = 3'd1,
    OP_KEXP  = 3'd2,
    OP_LOAD  = 3'd3,
    OP_ROUND = 3'd4,
    OP_LAST  = 3'd5,
    OP_KEY   = 3'd6
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic                dec;
    logic [RkAddrW-1:0]  rk_addr;   // round-key word written during expansion
    logic [3:0]          rnd;       // round key read for the next cycle
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] nk;
    logic [3:0] nr;
  } dp_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [11] = '{
    8'h8d,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_ctrl.sv =====
`default_nettype none
module aes_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr,
  input  wire logic              in_go,
  input  wire logic              req_dec,
  input  wire logic              out_busy,
  input  wire aes_pkg::dp_stat_t stat,
  output aes_pkg::dp_cmd_t       cmd,
  output logic                   ready_in,
  output logic                   cfg_ready,
  output logic                   out_load
);

  typedef enum logic [5:0] {
    S_EXP_INIT = 6'b000001,
    S_EXP      = 6'b000010,
    S_IDLE     = 6'b000100,
    S_KEY      = 6'b001000,
    S_RUN      = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t                          state, state_next;
  logic [aes_pkg::RkAddrW-1:0]     widx, widx_next;
  logic [3:0]                      rnd, rnd_next;
  logic                            dec, dec_next;
  logic [aes_pkg::RkAddrW-1:0]     total;

  // Schedule length: 4 * (Nr + 1) words.
  assign total = {stat.nr + 4'd1, 2'b00};

  // State register and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EXP_INIT;
      widx  <= '0;
      rnd   <= '0;
      dec   <= 1'b0;
    end else begin
      state <= state_next;
      widx  <= widx_next;
      rnd   <= rnd_next;
      dec   <= dec_next;
    end
  end

  // Next-state logic and command generation. The round key is read in the
  // cycle before its use, so cmd.rnd names the round of the next cycle.
  always_comb begin
    state_next  = state;
    widx_next   = widx;
    rnd_next    = rnd;
    dec_next    = dec;
    cmd         = '{op: aes_pkg::OP_NONE, dec: dec, rk_addr: '0, rnd: rnd};
    ready_in    = 1'b0;
    cfg_ready   = 1'b0;
    out_load    = 1'b0;
    case (state)
      S_EXP_INIT: begin
        widx_next  = '0;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.rk_addr = widx;
        cmd.op = (widx < {2'b00, stat.nk}) ? aes_pkg::OP_KLOAD : aes_pkg::OP_KEXP;
        widx_next = widx + 1'b1;
        if (widx_next == total) state_next = S_IDLE;
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        ready_in  = 1'b1;
        if (cfg_wr) begin
          state_next = S_EXP_INIT;
        end else if (in_go) begin
          dec_next    = req_dec;
          cmd.op      = aes_pkg::OP_LOAD;
          cmd.dec     = req_dec;
          cmd.rnd     = req_dec ? stat.nr : 4'd0;
          rnd_next    = req_dec ? stat.nr - 4'd1 : 4'd1;
          state_next  = S_KEY;
        end
      end
      S_KEY: begin
        cmd.op     = aes_pkg::OP_KEY;
        cmd.rnd    = rnd;
        state_next = S_RUN;
      end
      S_RUN: begin
        if ((!dec && rnd == stat.nr) || (dec && rnd == 4'd0)) begin
          cmd.op     = aes_pkg::OP_LAST;
          state_next = S_DONE;
        end else begin
          cmd.op   = aes_pkg::OP_ROUND;
          rnd_next = dec ? rnd - 4'd1 : rnd + 4'd1;
          cmd.rnd  = rnd_next;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_EXP_INIT;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/aes_datapath.sv =====
`default_nettype none
module aes_datapath (
  input  wire logic              clk,
  input  wire logic [1:0]        key_size,
  input  wire logic [63:0]       key_word_0,
  input  wire logic [63:0]       key_word_1,
  input  wire logic [63:0]       key_word_2,
  input  wire logic [63:0]       key_word_3,
  input  wire logic [63:0]       block_high,
  input  wire logic [63:0]       block_low,
  input  wire aes_pkg::dp_cmd_t  cmd,
  output aes_pkg::dp_stat_t      stat,
  output logic [127:0]           state_out
);

  logic [127:0] rk_mem [aes_pkg::RkRounds];
  logic [127:0] st;
  logic [31:0]  win [8];      // sliding window of the last eight schedule words
  logic [31:0]  kw_new;
  logic [31:0]  kprev, kback, ktmp, krot;
  logic [3:0]   kpos;         // position within the key period
  logic [3:0]   kcnt;         // period counter for the round constant
  logic [127:0] rkey;
  logic [127:0] sb, sr, mc, after;
  logic [255:0] key_all;

  // Key length and round count.
  always_comb begin
    case (key_size)
      2'd0:    stat = '{nk: 4'd4, nr: 4'd10};
      2'd1:    stat = '{nk: 4'd6, nr: 4'd12};
      default: stat = '{nk: 4'd8, nr: 4'd14};
    endcase
  end

  assign key_all = {key_word_0, key_word_1, key_word_2, key_word_3};

  // Schedule word: either a key word or one step of the expansion.
  always_comb begin
    kprev = win[0];
    kback = win[3'(stat.nk - 4'd1)];
    krot  = {kprev[23:0], kprev[31:24]};
    ktmp  = kprev;
    if (kpos == 4'd0) begin
      ktmp = {aes_pkg::SBOX[krot[31:24]], aes_pkg::SBOX[krot[23:16]],
              aes_pkg::SBOX[krot[15:8]], aes_pkg::SBOX[krot[7:0]]}
             ^ {aes_pkg::RCON[kcnt], 24'h0};
    end else if (stat.nk == 4'd8 && kpos == 4'd4) begin
      ktmp = {aes_pkg::SBOX[kprev[31:24]], aes_pkg::SBOX[kprev[23:16]],
              aes_pkg::SBOX[kprev[15:8]], aes_pkg::SBOX[kprev[7:0]]};
    end
    if (cmd.op == aes_pkg::OP_KLOAD) begin
      kw_new = key_all[255 - 32*cmd.rk_addr[2:0] -: 32];
    end else begin
      kw_new = kback ^ ktmp;
    end
  end

  // Round-key store and schedule window; each word lands in its round entry.
  always_ff @(posedge clk) begin
    if (cmd.op == aes_pkg::OP_KLOAD || cmd.op == aes_pkg::OP_KEXP) begin
      rk_mem[cmd.rk_addr[5:2]][127 - 32*cmd.rk_addr[1:0] -: 32] <= kw_new;
      for (int i = 7; i > 0; i--) win[i] <= win[i-1];
      win[0] <= kw_new;
      if (cmd.op == aes_pkg::OP_KLOAD) begin
        kpos <= (cmd.rk_addr + 1'b1 == {2'b00, stat.nk}) ? 4'd0 : 4'd15;
        kcnt <= 4'd1;
      end else if (kpos + 4'd1 == stat.nk) begin
        kpos <= 4'd0;
        kcnt <= kcnt + 4'd1;
      end else begin
        kpos <= kpos + 4'd1;
      end
    end
  end

  // Registered read of the round key used in the next cycle.
  always_ff @(posedge clk) begin
    rkey <= rk_mem[cmd.rnd];
  end

  // Round functions.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[127 - 8*i -: 8] = cmd.dec ? aes_pkg::INV_SBOX[st[127 - 8*i -: 8]]
                                   : aes_pkg::SBOX[st[127 - 8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (cmd.dec) sr[127 - 8*(((c + r) % 4)*4 + r) -: 8] = sb[127 - 8*(c*4 + r) -: 8];
        else         sr[127 - 8*(c*4 + r) -: 8] = sb[127 - 8*(((c + r) % 4)*4 + r) -: 8];
      end
    end
  end

  // Mix columns, forward or inverse, on a given word.
  function automatic logic [31:0] mix(input logic [31:0] w, input logic inv);
    logic [7:0] a, b, d, e, all, u, v;
    a = w[31:24]; b = w[23:16]; d = w[15:8]; e = w[7:0];
    if (inv) begin
      u = aes_pkg::xtime(aes_pkg::xtime(a ^ d));
      v = aes_pkg::xtime(aes_pkg::xtime(b ^ e));
      a = a ^ u; b = b ^ v; d = d ^ u; e = e ^ v;
    end
    all = a ^ b ^ d ^ e;
    mix = {a ^ all ^ aes_pkg::xtime(a ^ b), b ^ all ^ aes_pkg::xtime(b ^ d),
           d ^ all ^ aes_pkg::xtime(d ^ e), e ^ all ^ aes_pkg::xtime(e ^ a)};
  endfunction

  // Round assembly: decryption adds the key before the inverse mix.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mc[127 - 32*c -: 32] = cmd.dec ? mix(sr[127 - 32*c -: 32] ^ rkey[127 - 32*c -: 32], 1'b1)
                                     : mix(sr[127 - 32*c -: 32], 1'b0) ^ rkey[127 - 32*c -: 32];
    end
    after = (cmd.op == aes_pkg::OP_LAST) ? (sr ^ rkey) : mc;
  end

  // Cipher state register: the block is loaded, the first key is added, then each round result is stored.
  always_ff @(posedge clk) begin
    case (cmd.op)
      aes_pkg::OP_LOAD:  st <= {block_high, block_low};
      aes_pkg::OP_KEY:   st <= st ^ rkey;
      aes_pkg::OP_ROUND: st <= after;
      aes_pkg::OP_LAST:  st <= after;
      default:           st <= st;
    endcase
  end

  assign state_out = st;

endmodule
`default_nettype wire

// ===== hdl/aes_block_cipher.sv =====
`default_nettype none
// AES-128/192/256 block cipher, one block per item, encrypt or decrypt.
// The accept cycle loads the block, the next cycle adds the first round
// key, and then one round runs per cycle in the shared round unit, with
// the round key read through a register. After the last round the result
// enters the output register once the output is not stalled. A new item
// is taken once the result has moved into the output register. After
// reset and after every configuration write the key schedule is expanded
// into the round-key store, one word per cycle; no item or write is
// accepted until it completes. While a write is offered, items are stalled.
// Key size code three acts as 256 bits.
`include "aes_block_cipher_macros.svh"
module aes_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [63:0] block_high,
  input  wire logic [63:0] block_low,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      result_high,
  output logic [63:0]      result_low
);

  logic [1:0]        key_size;
  logic [63:0]       key_word_0, key_word_1, key_word_2, key_word_3;
  aes_pkg::dp_cmd_t  cmd;
  aes_pkg::dp_stat_t stat;
  logic [127:0]      st;
  logic              ready_in, out_load, cfg_wr, in_go;

  assign cfg_wr   = cfg_valid && cfg_ready;
  assign in_stall = !ready_in || cfg_valid;
  assign in_go    = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= '0; key_word_0 <= '0; key_word_1 <= '0;
      key_word_2 <= '0; key_word_3 <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        aes_pkg::REG_KEY_SIZE: key_size   <= cfg_data[1:0];
        aes_pkg::REG_KEY_W0:   key_word_0 <= cfg_data;
        aes_pkg::REG_KEY_W1:   key_word_1 <= cfg_data;
        aes_pkg::REG_KEY_W2:   key_word_2 <= cfg_data;
        aes_pkg::REG_KEY_W3:   key_word_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_ctrl u_ctrl (
    .clk, .rst, .cfg_wr, .in_go, .req_dec(req_type),
    .out_busy(out_valid && out_stall), .stat, .cmd,
    .ready_in, .cfg_ready, .out_load
  );

  aes_datapath u_dp (
    .clk, .key_size, .key_word_0, .key_word_1, .key_word_2, .key_word_3,
    .block_high, .block_low, .cmd, .stat, .state_out(st)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) {result_high, result_low} <= st;
  end

  `AES_ASSERT_IMP(a_no_load_when_held, out_valid && out_stall, !out_load,
                  "result overwritten while stalled")
  `AES_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall,
                   "second item accepted while busy")
  `AES_ASSERT_IMP(a_cfg_idle, cfg_ready, ready_in,
                  "configuration taken while not idle")

endmodule
`default_nettype wire
